// ----- rtl/core/acrfd_pkg.sv -----
package acrfd_pkg;

	localparam int unsigned PosW   = 5;
	localparam int unsigned CapN   = 5;
	localparam int unsigned OutW   = 40;

	localparam logic [PosW-1:0] PosCap    = 5'd22;
	localparam logic [PosW-1:0] PosFirst  = 5'd8;
	localparam logic [PosW-1:0] PosLastOn = 5'd13;
	localparam logic [PosW-1:0] PosLastOff = 5'd20;

	localparam logic [7:0] HdrByte0   = 8'h02;
	localparam logic [7:0] HdrByte1Off = 8'hB2;
	localparam logic [7:0] HdrByte1On  = 8'h92;
	localparam logic [7:0] HdrByte2   = 8'h0F;
	localparam logic [7:0] CsTail     = 8'h02;
	localparam logic [7:0] Byte9Mask  = 8'hFE;
	localparam logic [5:0] CsBase     = 6'd28;

	// header flag bit positions
	localparam int unsigned FlagB0  = 0;
	localparam int unsigned FlagOff = 1;
	localparam int unsigned FlagOn  = 2;
	localparam int unsigned FlagB2  = 3;

	localparam logic [2:0] ModeUnknown = 3'd5;
	localparam logic [3:0] ModeMaxNib  = 4'd4;

	localparam logic [2:0] FanAuto    = 3'd0;
	localparam logic [2:0] FanOne     = 3'd1;
	localparam logic [2:0] FanTwo     = 3'd2;
	localparam logic [2:0] FanThree   = 3'd3;
	localparam logic [2:0] FanFour    = 3'd4;
	localparam logic [2:0] FanUnknown = 3'd5;

	localparam logic [3:0] AirOffNib = 4'hF;
	localparam logic [3:0] AirOnNib  = 4'hA;
	localparam logic [1:0] AirOff     = 2'd0;
	localparam logic [1:0] AirOn      = 2'd1;
	localparam logic [1:0] AirUnknown = 2'd2;

	localparam logic [3:0] TurboOffNib = 4'h1;
	localparam logic [3:0] TurboOnNib  = 4'h7;
	localparam logic [1:0] TurboOff     = 2'd0;
	localparam logic [1:0] TurboOn      = 2'd1;
	localparam logic [1:0] TurboUnknown = 2'd2;

	typedef logic [CapN-1:0][7:0] cap_bytes_t;

	typedef struct packed {
		logic [7:0] received_checksum;
		logic [7:0] computed_checksum;
		logic       checksum_match;
		logic [1:0] turbo;
		logic [1:0] airflow;
		logic [2:0] fan_speed;
		logic [4:0] temperature;
		logic [2:0] mode;
		logic       power_on;
		logic       recognized;
	} result_t;

	function automatic logic [2:0] fan_code(input logic [3:0] nib);
		logic [2:0] code;
		case (nib)
			4'h1:    code = FanAuto;
			4'h5:    code = FanOne;
			4'h9:    code = FanTwo;
			4'hB:    code = FanThree;
			4'hF:    code = FanFour;
			default: code = FanUnknown;
		endcase
		return code;
	endfunction

	function automatic logic [3:0] ones8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, v[i]};
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/acrfd_decode.sv -----
module acrfd_decode
	import acrfd_pkg::*;
(
	input  logic [PosW-1:0] pos,
	input  logic [3:0]      flags,
	input  cap_bytes_t      cap,
	output result_t         res
);

	logic       hdr_ok;
	logic       off_frame;
	logic       on_frame;
	logic [5:0] ones;
	logic [5:0] cs_diff;
	logic [7:0] cs;
	logic [7:0] b8, b9, b10, b11, b12;

	assign b8  = cap[0];
	assign b9  = cap[1];
	assign b10 = cap[2];
	assign b11 = cap[3];
	assign b12 = cap[4];

	assign hdr_ok    = flags[FlagB0] & flags[FlagB2];
	assign off_frame = hdr_ok & (pos == PosLastOff) & flags[FlagOff];
	assign on_frame  = hdr_ok & (pos == PosLastOn) & flags[FlagOn];

	assign ones = {2'd0, ones8(b9 & Byte9Mask)} + {2'd0, ones8(b10)}
		+ {2'd0, ones8(b11)} + {2'd0, ones8(b12)};
	assign cs_diff = CsBase - ones;
	assign cs      = {cs_diff[3:0], 4'd0} | CsTail;

	always_comb begin
		res = '0;
		res.recognized = off_frame | on_frame;
		if (on_frame) begin
			res.power_on          = 1'b1;
			res.mode              = (b12[7:4] <= ModeMaxNib) ? b12[6:4] : ModeUnknown;
			res.temperature       = {1'b1, b11[7:4]};
			res.fan_speed         = fan_code(b12[3:0]);
			res.airflow           = (b9[7:4] == AirOffNib) ? AirOff :
				(b9[7:4] == AirOnNib) ? AirOn : AirUnknown;
			res.turbo             = (b10[3:0] == TurboOffNib) ? TurboOff :
				(b10[3:0] == TurboOnNib) ? TurboOn : TurboUnknown;
			res.checksum_match    = (cs == b8);
			res.computed_checksum = cs;
			res.received_checksum = b8;
		end
	end

endmodule

// ----- rtl/core/ac_remote_frame_decoder.sv -----
// Flow: a byte accepted into the input register is parsed there and, if final,
//   registered as a result in the result register, which drives m_tvalid.
// Throughput: one byte per cycle; the input register and the result register
//   are the only stages, and the last byte of a frame waits only while a
//   previous result is still held and not taken.
// Reset: arst_n clears the stage valid flags, byte position and header flags.
module ac_remote_frame_decoder
	import acrfd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,   // [7:0] data_byte
	input  logic            s_tlast,   // last_byte
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [OutW-1:0] m_tdata    // recognized, power_on, mode, temperature, fan_speed,
	                                   // airflow, turbo, checksum_match, computed_checksum,
	                                   // received_checksum, zero fill
);

	// input register
	logic            valid_s1;
	logic [7:0]      data_s1;
	logic            last_s1;

	// frame state
	logic [PosW-1:0] pos_q;
	logic [3:0]      flags_q;
	cap_bytes_t      cap_q;

	// result register
	logic            out_valid_q;
	result_t         out_q;

	logic            out_free;
	logic            fire_s1;
	logic            in_fire;
	result_t         res;

	// the result slot is free if empty or being emptied this cycle
	assign out_free = ~out_valid_q | m_tready;
	// a non-final byte always advances; a final byte needs the result slot
	assign fire_s1  = valid_s1 & (~last_s1 | out_free);
	assign s_tready = ~valid_s1 | fire_s1;
	assign in_fire  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// track position and header matches; restart after every final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			flags_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				pos_q   <= '0;
				flags_q <= '0;
			end else begin
				if (pos_q < PosCap) begin
					pos_q <= pos_q + 1'b1;
				end
				if (pos_q == 5'd0 && data_s1 == HdrByte0) begin
					flags_q[FlagB0] <= 1'b1;
				end
				if (pos_q == 5'd1 && data_s1 == HdrByte1Off) begin
					flags_q[FlagOff] <= 1'b1;
				end
				if (pos_q == 5'd1 && data_s1 == HdrByte1On) begin
					flags_q[FlagOn] <= 1'b1;
				end
				if (pos_q == 5'd2 && data_s1 == HdrByte2) begin
					flags_q[FlagB2] <= 1'b1;
				end
			end
		end
	end

	// capture bytes 8 to 12; a final byte there never yields a decoded frame
	always_ff @(posedge clk) begin
		for (int k = 0; k < CapN; k++) begin
			if (fire_s1 && pos_q == PosFirst + PosW'(k)) begin
				cap_q[k] <= data_s1;
			end
		end
	end

	acrfd_decode u_decode (
		.pos   (pos_q),
		.flags (flags_q),
		.cap   (cap_q),
		.res   (res)
	);

	// hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OutW - $bits(result_t))'(0), out_q};

	// frame state restarts after a final byte
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> (pos_q == 5'd0 && flags_q == 4'd0))
		else $error("frame state not cleared after final byte");

	// position saturates
	a_pos_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosCap)
		else $error("byte position beyond saturation");

	// a new result appears only from a parsed final byte
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire_s1 && last_s1))
		else $error("result without final byte");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(fire_s1 && last_s1))
		else $error("held result overwritten");

	// power on implies recognized
	a_on_recog: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.power_on) |-> out_q.recognized)
		else $error("power on without recognition");

endmodule

// ----- tb/ac_remote_frame_decoder_checker.sv -----
`timescale 1ns / 100ps

module ac_remote_frame_decoder_checker
	import acrfd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tready,
	input  logic [7:0]      s_tdata,   // [7:0] data_byte
	input  logic            s_tlast,   // last_byte
	input  logic            m_tvalid,
	input  logic            m_tready,
	input  logic [OutW-1:0] m_tdata,   // result fields, recognized lowest, then zero fill
	output int unsigned     errors,
	output int unsigned     pending
);

	localparam int unsigned ResW   = $bits(result_t);
	localparam int unsigned OnLen  = 14;
	localparam int unsigned OffLen = 21;

	logic [PosW-1:0] frame_pos;
	logic [3:0]      hdr_seen;
	logic [7:0]      tail_bytes [CapN];
	result_t         decoded_q [$];
	int unsigned     mismatch_count = 0;
	int unsigned     frames_waiting = 0;

	assign errors  = mismatch_count;
	assign pending = frames_waiting;

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t     want;
		result_t     got;
		logic [7:0]  b8, b9, b10, b11, b12;
		int unsigned frame_len;
		int          ones;
		logic [3:0]  cs_nib;
		logic        hdr_ok;

		if (!arst_n) begin
			frame_pos = '0;
			hdr_seen  = '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[ResW-1:0];
				if (decoded_q.size() == 0) begin
					$error("result with no frame outstanding: 0x%0h", m_tdata);
					mismatch_count++;
				end else begin
					want = decoded_q.pop_front();
					frames_waiting--;
					check_field("recognized", want.recognized, got.recognized);
					check_field("power_on", want.power_on, got.power_on);
					check_field("mode", want.mode, got.mode);
					check_field("temperature", want.temperature, got.temperature);
					check_field("fan_speed", want.fan_speed, got.fan_speed);
					check_field("airflow", want.airflow, got.airflow);
					check_field("turbo", want.turbo, got.turbo);
					check_field("checksum_match", want.checksum_match, got.checksum_match);
					check_field("computed_checksum", want.computed_checksum,
						got.computed_checksum);
					check_field("received_checksum", want.received_checksum,
						got.received_checksum);
					check_field("zero fill", 0, m_tdata[OutW-1:ResW]);
				end
			end

			if (s_tvalid && s_tready) begin
				if (frame_pos == 0 && s_tdata == HdrByte0)    hdr_seen[FlagB0]  = 1'b1;
				if (frame_pos == 1 && s_tdata == HdrByte1Off) hdr_seen[FlagOff] = 1'b1;
				if (frame_pos == 1 && s_tdata == HdrByte1On)  hdr_seen[FlagOn]  = 1'b1;
				if (frame_pos == 2 && s_tdata == HdrByte2)    hdr_seen[FlagB2]  = 1'b1;
				if (frame_pos >= PosFirst && frame_pos < PosFirst + CapN)
					tail_bytes[int'(frame_pos - PosFirst)] = s_tdata;

				if (!s_tlast) begin
					if (frame_pos < PosCap) frame_pos = frame_pos + 1'b1;
				end else begin
					// length saturates, so an overlong frame reads as 22 bytes
					frame_len = (frame_pos >= PosCap - 1) ? PosCap : frame_pos + 1;
					hdr_ok    = hdr_seen[FlagB0] && hdr_seen[FlagB2];
					want      = '0;
					if (hdr_ok && frame_len == OffLen && hdr_seen[FlagOff])
						want.recognized = 1'b1;
					if (hdr_ok && frame_len == OnLen && hdr_seen[FlagOn]) begin
						b8  = tail_bytes[0];
						b9  = tail_bytes[1];
						b10 = tail_bytes[2];
						b11 = tail_bytes[3];
						b12 = tail_bytes[4];
						want.recognized  = 1'b1;
						want.power_on    = 1'b1;
						want.mode        = (b12[7:4] <= ModeMaxNib) ? b12[6:4] : ModeUnknown;
						want.temperature = {1'b1, b11[7:4]};
						case (b12[3:0])
							4'h1:    want.fan_speed = FanAuto;
							4'h5:    want.fan_speed = FanOne;
							4'h9:    want.fan_speed = FanTwo;
							4'hB:    want.fan_speed = FanThree;
							4'hF:    want.fan_speed = FanFour;
							default: want.fan_speed = FanUnknown;
						endcase
						want.airflow = (b9[7:4] == AirOffNib) ? AirOff :
							(b9[7:4] == AirOnNib) ? AirOn : AirUnknown;
						want.turbo = (b10[3:0] == TurboOffNib) ? TurboOff :
							(b10[3:0] == TurboOnNib) ? TurboOn : TurboUnknown;
						ones = $countones(b9 & Byte9Mask) + $countones(b10) +
							$countones(b11) + $countones(b12);
						cs_nib = 4'(int'(CsBase) - ones);
						want.computed_checksum = {cs_nib, 4'h0} | CsTail;
						want.checksum_match    = (want.computed_checksum == b8);
						want.received_checksum = b8;
					end
					decoded_q.push_back(want);
					frames_waiting++;
					frame_pos = '0;
					hdr_seen  = '0;
				end
			end
		end
	end

endmodule

// ----- tb/ac_remote_frame_decoder_tb.sv -----
`timescale 1ns / 100ps

module ac_remote_frame_decoder_tb;
	import acrfd_pkg::*;

	localparam int unsigned ByteTarget = 2000;
	// longest legal silence: the longest source gap plus the longest sink stall,
	// taken many times over
	localparam int unsigned QuietLimit = 2000;
	// result is raised from the result register after the last byte leaves the input register; allow some slack
	localparam int unsigned TailCycles = 8;
	localparam int unsigned OnLen      = 14;
	localparam int unsigned OffLen     = 21;

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            s_tvalid = 1'b0;
	logic [7:0]      s_tdata  = '0;
	logic            s_tlast  = 1'b0;
	logic            m_tready = 1'b0;
	wire             s_tready;
	wire             m_tvalid;
	wire  [OutW-1:0] m_tdata;

	int unsigned errors;
	int unsigned pending;

	bit          src_calm     = 1'b0;
	bit          sink_calm    = 1'b0;
	int unsigned sink_wait    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned bytes_sent   = 0;
	logic [7:0]  frame_buf [$];

	always #4 clk = ~clk;

	ac_remote_frame_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] data_byte
		.s_tlast  (s_tlast),   // last_byte
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // result fields, recognized lowest, then zero fill
	);

	ac_remote_frame_decoder_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// Result sink: mostly short stalls, the odd long one, and calm stretches
	// where every result is taken at once. Drive on the falling edge.
	always @(negedge clk) begin : sink_pace
		int unsigned r;
		if ($urandom_range(0, 199) == 0) sink_calm <= !sink_calm;
		if (sink_wait != 0) begin
			m_tready  <= 1'b0;
			sink_wait <= sink_wait - 1;
		end else begin
			m_tready <= 1'b1;
			if (!sink_calm) begin
				r = $urandom_range(0, 99);
				if (r < 30)
					sink_wait <= $urandom_range(1, 3);
				else if (r < 35)
					sink_wait <= $urandom_range(4, 40);
			end
		end
	end

	// Watchdog: end the run if no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QuietLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Offer one byte after a random gap and hold it until the decoder takes it.
	// Return at the falling edge after acceptance with tvalid still high, so a
	// back-to-back byte never lowers and raises tvalid in the same step.
	task automatic push_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		int unsigned r;
		r   = $urandom_range(0, 99);
		gap = 0;
		if (!src_calm) begin
			if (r >= 90)
				gap = $urandom_range(4, 30);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Send the frame held in frame_buf; roughly one frame in four goes out
	// with no source gaps at all.
	task automatic send_frame();
		src_calm = ($urandom_range(0, 3) == 0);
		foreach (frame_buf[i])
			push_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// Build n bytes with the given header, random elsewhere.
	task automatic fill_frame(input int unsigned n, input logic [7:0] h0,
			input logic [7:0] h1, input logic [7:0] h2);
		frame_buf = {};
		for (int unsigned i = 0; i < n; i++)
			frame_buf.push_back(i == 0 ? h0 : i == 1 ? h1 : i == 2 ? h2 :
				8'($urandom));
	endtask

	// Power-on frame with the given settings bytes; a bad checksum is the
	// right one with at least one bit flipped.
	task automatic on_frame(input logic [7:0] b9, input logic [7:0] b10,
			input logic [7:0] b11, input logic [7:0] b12, input bit good_cs);
		logic [7:0] cs;
		fill_frame(OnLen, HdrByte0, HdrByte1On, HdrByte2);
		cs = {4'(int'(CsBase) - ($countones(b9 & Byte9Mask) + $countones(b10) +
			$countones(b11) + $countones(b12))), 4'h0} | CsTail;
		frame_buf[8]  = good_cs ? cs : cs ^ 8'($urandom_range(1, 255));
		frame_buf[9]  = b9;
		frame_buf[10] = b10;
		frame_buf[11] = b11;
		frame_buf[12] = b12;
		send_frame();
	endtask

	initial begin
		int unsigned r;
		int unsigned n;
		logic [7:0]  b9, b10, b11, b12, h0, h1, h2;
		logic [3:0]  fan_nib;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every listed code, unknown codes, temperature extremes,
		// the masked bit 0 of byte 9, good and bad checksums.
		on_frame(8'hF0, 8'h01, 8'h00, 8'h01, 1'b1);
		on_frame(8'hA1, 8'h07, 8'hFF, 8'h15, 1'b1);
		on_frame(8'h31, 8'hF2, 8'h8F, 8'h29, 1'b0);
		on_frame(8'hFF, 8'hFF, 8'hFF, 8'h3B, 1'b1);
		on_frame(8'h00, 8'h00, 8'h00, 8'h4F, 1'b1);
		on_frame(8'hF0, 8'h01, 8'h70, 8'h50, 1'b1);
		on_frame(8'hA0, 8'h07, 8'h30, 8'hFE, 1'b0);
		// power-off frame
		fill_frame(OffLen, HdrByte0, HdrByte1Off, HdrByte2);
		send_frame();
		// broken headers and lengths: each must come back unrecognised
		fill_frame(OnLen, 8'h03, HdrByte1On, HdrByte2);
		send_frame();
		fill_frame(OnLen, HdrByte0, HdrByte1On, 8'h0E);
		send_frame();
		fill_frame(OnLen - 1, HdrByte0, HdrByte1On, HdrByte2);
		send_frame();
		fill_frame(OnLen + 1, HdrByte0, HdrByte1On, HdrByte2);
		send_frame();
		fill_frame(OffLen, HdrByte0, HdrByte1On, HdrByte2);
		send_frame();
		fill_frame(OnLen, HdrByte0, HdrByte1Off, HdrByte2);
		send_frame();
		fill_frame(OffLen - 1, HdrByte0, HdrByte1Off, HdrByte2);
		send_frame();
		fill_frame(1, HdrByte0, HdrByte1On, HdrByte2);
		send_frame();
		// overlong: length saturates, extra bytes ignored
		fill_frame(22, HdrByte0, HdrByte1Off, HdrByte2);
		send_frame();
		fill_frame(30, HdrByte0, HdrByte1Off, HdrByte2);
		send_frame();

		// Random: mostly well-formed frames with random settings, mixed with
		// near-miss headers and lengths and plain noise.
		while (bytes_sent < ByteTarget) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				b9  = 8'($urandom);
				b10 = 8'($urandom);
				b11 = 8'($urandom);
				b12 = 8'($urandom);
				case ($urandom_range(0, 2))
					0: b9[7:4] = AirOffNib;
					1: b9[7:4] = AirOnNib;
					default: ;
				endcase
				case ($urandom_range(0, 2))
					0: b10[3:0] = TurboOffNib;
					1: b10[3:0] = TurboOnNib;
					default: ;
				endcase
				if ($urandom_range(0, 9) < 7) b12[7:4] = 4'($urandom_range(0, 5));
				case ($urandom_range(0, 5))
					0: fan_nib = 4'h1;
					1: fan_nib = 4'h5;
					2: fan_nib = 4'h9;
					3: fan_nib = 4'hB;
					4: fan_nib = 4'hF;
					default: fan_nib = 4'($urandom);
				endcase
				b12[3:0] = fan_nib;
				on_frame(b9, b10, b11, b12, $urandom_range(0, 9) < 7);
			end else if (r < 70) begin
				fill_frame(OffLen, HdrByte0, HdrByte1Off, HdrByte2);
				send_frame();
			end else if (r < 85) begin
				case ($urandom_range(0, 3))
					0: n = OnLen - 1 + $urandom_range(0, 2);
					1: n = OffLen - 1 + $urandom_range(0, 2);
					2: n = $urandom_range(1, 3);
					default: n = $urandom_range(22, 30);
				endcase
				h0 = $urandom_range(0, 1) ? HdrByte0 : 8'($urandom);
				case ($urandom_range(0, 2))
					0: h1 = HdrByte1On;
					1: h1 = HdrByte1Off;
					default: h1 = 8'($urandom);
				endcase
				h2 = $urandom_range(0, 1) ? HdrByte2 : 8'($urandom);
				fill_frame(n, h0, h1, h2);
				send_frame();
			end else begin
				fill_frame($urandom_range(1, 30), 8'($urandom), 8'($urandom),
					8'($urandom));
				send_frame();
			end
		end
		s_tvalid <= 1'b0;

		// drain: wait for every outstanding result, then let the pipeline settle
		while (pending != 0) @(negedge clk);
		repeat (TailCycles) @(negedge clk);

		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/acrfd_pkg.sv
rtl/core/acrfd_decode.sv
rtl/core/ac_remote_frame_decoder.sv
tb/ac_remote_frame_decoder_checker.sv
tb/ac_remote_frame_decoder_tb.sv
